>>> rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, constants, types and angle tables of the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

   // Field widths of the channels.
   localparam int IN_W    = 16;
   localparam int ROLL_W  = 16;
   localparam int PITCH_W = 15;
   localparam int YAW_W   = 16;

   // Defaults of the top-level parameters.
   localparam int CORDIC_STEPS_DEF = 14;
   localparam int FRAC_BITS_DEF    = 14;
   localparam int ATAN_TAB_LEN     = 24;

   // Internal arithmetic widths.
   localparam int PROD_W    = 32;          // product of two components
   localparam int S_W       = 35;          // doubled sums, Q.28
   localparam int V_W       = 38;          // CORDIC vector, with gain headroom
   localparam int MAG_W     = 28;          // magnitude of an unsaturated sine
   localparam int N_W       = 58;          // radicand of the square root
   localparam int ISQ_STEPS = N_W / 2;     // one result bit per stage
   localparam int RT_W      = ISQ_STEPS;   // root width
   localparam int RM_W      = RT_W + 3;    // partial remainder width

   localparam int QUEUE_DEPTH = 4;

   // Fixed-point constants.
   localparam logic signed [S_W-1:0] Q28_ONE      = S_W'(64'sd1 << 28);
   localparam logic [N_W-1:0]        Q56_ONE      = N_W'(64'd1 << 56);
   localparam logic signed [15:0]    ANG_MAX_PI   = 16'sd25736;
   localparam logic signed [15:0]    ANG_MAX_HALF = 16'sd12868;
   localparam longint                HALF_PI_Q30  = 64'sd1686629713;

   // One classified item waiting between front and back.
   typedef struct packed {
      logic signed [S_W-1:0] sr;
      logic signed [S_W-1:0] cr;
      logic signed [S_W-1:0] sy;
      logic signed [S_W-1:0] cy;
      logic signed [S_W-1:0] sp;
      logic [MAG_W-1:0]      mag;
      logic                  clamp;
   } job_type;

   // Number of CORDIC iterations actually built.
   function automatic int steps_eff(input int steps);
      return (steps > ATAN_TAB_LEN) ? ATAN_TAB_LEN : steps;
   endfunction

   // atan(2^-i) in Q.30, rounded to nearest.
   function automatic longint atan_q30(input int i);
      longint v;
      v = 64'sd0;
      unique case (i)
         0:  v = 64'sd843314857;
         1:  v = 64'sd497837829;
         2:  v = 64'sd263043837;
         3:  v = 64'sd133525159;
         4:  v = 64'sd67021687;
         5:  v = 64'sd33543516;
         6:  v = 64'sd16775851;
         7:  v = 64'sd8388437;
         8:  v = 64'sd4194283;
         9:  v = 64'sd2097149;
         10: v = 64'sd1048576;
         11: v = 64'sd524288;
         12: v = 64'sd262144;
         13: v = 64'sd131072;
         14: v = 64'sd65536;
         15: v = 64'sd32768;
         16: v = 64'sd16384;
         17: v = 64'sd8192;
         18: v = 64'sd4096;
         19: v = 64'sd2048;
         20: v = 64'sd1024;
         21: v = 64'sd512;
         22: v = 64'sd256;
         23: v = 64'sd128;
         default: v = 64'sd0;
      endcase
      return v;
   endfunction

   // Q.30 angle to the accumulator format, round half up.
   function automatic longint q30_to_ang(input longint v, input int frac);
      int s;
      s = 30 - frac;
      if (s == 0) begin
         return v;
      end
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

endpackage

`default_nettype wire

>>> rtl/q2e_req_if.sv
// ----------------------------------------------------------------------------
// q2e_req_if
// Request channel: one quaternion per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface q2e_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [q2e_pkg::IN_W-1:0]   qw;
   logic signed [q2e_pkg::IN_W-1:0]   qx;
   logic signed [q2e_pkg::IN_W-1:0]   qy;
   logic signed [q2e_pkg::IN_W-1:0]   qz;

   modport source (output valid, output qw, output qx, output qy, output qz, input ready);
   modport sink   (input valid, input qw, input qx, input qy, input qz, output ready);
endinterface

`default_nettype wire

>>> rtl/q2e_rsp_if.sv
// ----------------------------------------------------------------------------
// q2e_rsp_if
// Response channel: one set of Euler angles per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface q2e_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [q2e_pkg::ROLL_W-1:0]   roll;
   logic signed [q2e_pkg::PITCH_W-1:0]  pitch;
   logic signed [q2e_pkg::YAW_W-1:0]    yaw;
   logic                                pitch_clamped;

   modport source (output valid, output roll, output pitch, output yaw,
                   output pitch_clamped, input ready);
   modport sink   (input valid, input roll, input pitch, input yaw,
                   input pitch_clamped, output ready);
endinterface

`default_nettype wire

>>> rtl/quaternion_to_euler_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_core
// Converts attitude quaternions in Q2.14 into ZYX Euler angles in Q3.13 (pitch in Q2.13).
// ----------------------------------------------------------------------------
//   Channel    Direction  Carries
//   req_chan   in         qw, qx, qy, qz (Q2.14)
//   rsp_chan   out        roll, yaw (Q3.13), pitch (Q2.13), pitch_clamped
//
// One transaction is accepted per cycle while the queue has room. The response
// is formed by the square-root pipeline
// (one root bit per stage) followed by the
// CORDIC pipeline (one iteration per stage). Reset clears only valid flags,
// queue pointers, the queue fill count and the response valid. A stalled response freezes the
// back pipeline; the front keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_core #(
   parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = q2e_pkg::FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   q2e_req_if.sink   req_chan,
   q2e_rsp_if.source rsp_chan
);

   localparam int NS     = q2e_pkg::steps_eff(CORDIC_STEPS);
   localparam int CD_LAT = NS + 2;
   localparam int LAT    = q2e_pkg::ISQ_STEPS + 1 + CD_LAT;
   localparam int VW     = q2e_pkg::V_W;

   logic             push, full, pop, not_empty, back_en;
   q2e_pkg::job_type push_job, pop_job, sq_job;
   logic [q2e_pkg::RT_W-1:0] root;
   logic signed [15:0] roll_a, pitch_a, yaw_a;

   logic vld_ff [1:LAT];
   logic cl_ff  [1:CD_LAT];
   logic pos_ff [1:CD_LAT];

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [q2e_pkg::ROLL_W-1:0]  roll_ff;
   logic signed [q2e_pkg::PITCH_W-1:0] pitch_ff;
   logic signed [q2e_pkg::YAW_W-1:0]   yaw_ff;
   logic                               clamped_ff;
   logic signed [15:0]                 pitch_sel;

   // Front: products, sums and saturation test.
   q2e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .push     (push),
      .push_job (push_job),
      .full     (full)
   );

   q2e_queue #(.DEPTH(q2e_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop       (pop),
      .pop_job   (pop_job),
      .not_empty (not_empty)
   );

   // The back pipeline moves whenever the response register can load.
   assign back_en = ~rsp_valid_ff | rsp_chan.ready;
   assign pop     = back_en & not_empty;

   q2e_isqrt u_isqrt (
      .clock    (clock),
      .enable   (back_en),
      .job_in   (pop_job),
      .job_out  (sq_job),
      .root_out (root)
   );

   q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS),
                .LIMIT(q2e_pkg::ANG_MAX_PI)) u_roll (
      .clock  (clock),
      .enable (back_en),
      .y_in   (VW'(sq_job.sr)),
      .x_in   (VW'(sq_job.cr)),
      .angle  (roll_a)
   );

   q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS),
                .LIMIT(q2e_pkg::ANG_MAX_HALF)) u_pitch (
      .clock  (clock),
      .enable (back_en),
      .y_in   (VW'(sq_job.sp)),
      .x_in   (VW'($signed({1'b0, root}))),
      .angle  (pitch_a)
   );

   q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS),
                .LIMIT(q2e_pkg::ANG_MAX_PI)) u_yaw (
      .clock  (clock),
      .enable (back_en),
      .y_in   (VW'(sq_job.sy)),
      .x_in   (VW'(sq_job.cy)),
      .angle  (yaw_a)
   );

   // Valid flags along the back pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (back_en) begin
         vld_ff[1] <= pop;
         for (int k = 2; k <= LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Saturation flag and sign kept in step with the CORDIC units.
   always_ff @(posedge clock) begin
      if (back_en) begin
         cl_ff[1]  <= sq_job.clamp;
         pos_ff[1] <= (sq_job.sp > 0);
         for (int k = 2; k <= CD_LAT; k++) begin
            cl_ff[k]  <= cl_ff[k-1];
            pos_ff[k] <= pos_ff[k-1];
         end
      end
   end

   // Saturated pitch replaces the CORDIC result.
   always_comb begin
      if (cl_ff[CD_LAT]) begin
         pitch_sel = pos_ff[CD_LAT] ? q2e_pkg::ANG_MAX_HALF : -q2e_pkg::ANG_MAX_HALF;
      end else begin
         pitch_sel = pitch_a;
      end
   end

   // Response register.
   assign rsp_valid_in = back_en ? vld_ff[LAT] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         roll_ff    <= roll_a;
         pitch_ff   <= pitch_sel[q2e_pkg::PITCH_W-1:0];
         yaw_ff     <= yaw_a;
         clamped_ff <= cl_ff[CD_LAT];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.roll          = roll_ff;
   assign rsp_chan.pitch         = pitch_ff;
   assign rsp_chan.yaw           = yaw_ff;
   assign rsp_chan.pitch_clamped = clamped_ff;

   // The front never writes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   // A saturated pitch is exactly plus or minus half pi.
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.pitch_clamped) |->
      (rsp_chan.pitch == 15'sd12868 || rsp_chan.pitch == -15'sd12868))
      else $error("saturated pitch has a wrong value");

   // A stalled back pipeline keeps its last valid flag.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !back_en |=> $stable(vld_ff[LAT]))
      else $error("back pipeline moved while stalled");

endmodule

`default_nettype wire

>>> rtl/q2e_front.sv
// ----------------------------------------------------------------------------
// q2e_front
// Accepts quaternions, forms the component products and the atan2 and asin
// arguments, and classifies the pitch sine as saturated or not.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_front (
   input  wire logic        clock,
   input  wire logic        reset,
   q2e_req_if.sink          req_chan,
   output logic             push,
   output q2e_pkg::job_type push_job,
   input  wire logic        full
);

   localparam int PW = q2e_pkg::PROD_W;
   localparam int SW = q2e_pkg::S_W;

   logic f1_valid_ff, f1_valid_in;
   logic f2_valid_ff, f2_valid_in;
   logic en1, en2;

   logic signed [PW-1:0] p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_wz_ff;
   logic signed [PW-1:0] p_xy_ff, p_zz_ff, p_wy_ff, p_zx_ff;
   q2e_pkg::job_type     job_ff, job_in;

   // Each stage moves on when it is empty or the one after it moves.
   assign en2            = ~f2_valid_ff | ~full;
   assign en1            = ~f1_valid_ff | en2;
   assign req_chan.ready = en1;
   assign push           = f2_valid_ff & ~full;
   assign push_job       = job_ff;

   assign f1_valid_in = en1 ? req_chan.valid : f1_valid_ff;
   assign f2_valid_in = en2 ? f1_valid_ff : f2_valid_ff;

   // Doubled sums and the saturation test of the pitch sine.
   always_comb begin
      logic signed [SW-1:0] sp;
      sp = (SW'(p_wy_ff) - SW'(p_zx_ff)) <<< 1;
      job_in.sr    = (SW'(p_wx_ff) + SW'(p_yz_ff)) <<< 1;
      job_in.cr    = q2e_pkg::Q28_ONE - ((SW'(p_xx_ff) + SW'(p_yy_ff)) <<< 1);
      job_in.sy    = (SW'(p_wz_ff) + SW'(p_xy_ff)) <<< 1;
      job_in.cy    = q2e_pkg::Q28_ONE - ((SW'(p_yy_ff) + SW'(p_zz_ff)) <<< 1);
      job_in.sp    = sp;
      job_in.clamp = (sp >= q2e_pkg::Q28_ONE) || (sp <= -q2e_pkg::Q28_ONE);
      job_in.mag   = sp[SW-1] ? q2e_pkg::MAG_W'(-sp) : q2e_pkg::MAG_W'(sp);
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   // Product stage.
   always_ff @(posedge clock) begin
      if (en1) begin
         p_wx_ff <= req_chan.qw * req_chan.qx;
         p_yz_ff <= req_chan.qy * req_chan.qz;
         p_xx_ff <= req_chan.qx * req_chan.qx;
         p_yy_ff <= req_chan.qy * req_chan.qy;
         p_wz_ff <= req_chan.qw * req_chan.qz;
         p_xy_ff <= req_chan.qx * req_chan.qy;
         p_zz_ff <= req_chan.qz * req_chan.qz;
         p_wy_ff <= req_chan.qw * req_chan.qy;
         p_zx_ff <= req_chan.qz * req_chan.qx;
      end
   end

   // Sum stage.
   always_ff @(posedge clock) begin
      if (en2) begin
         job_ff <= job_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/q2e_queue.sv
// ----------------------------------------------------------------------------
// q2e_queue
// Short first-in first-out queue between the front and the back pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_queue #(
   parameter int DEPTH = q2e_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire q2e_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output q2e_pkg::job_type      pop_job,
   output logic                  not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   q2e_pkg::job_type  store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_pop    = pop & not_empty;
   assign pop_job   = store_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

>>> rtl/q2e_isqrt.sv
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pipelined floor square root of one minus the squared pitch sine, one root
// bit per stage; the rest of the item travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_isqrt (
   input  wire logic                        clock,
   input  wire logic                        enable,
   input  wire q2e_pkg::job_type            job_in,
   output q2e_pkg::job_type                 job_out,
   output logic [q2e_pkg::RT_W-1:0]         root_out
);

   localparam int NS  = q2e_pkg::ISQ_STEPS;
   localparam int NW  = q2e_pkg::N_W;
   localparam int RTW = q2e_pkg::RT_W;
   localparam int RMW = q2e_pkg::RM_W;

   logic [NW-1:0]    n_ff    [0:NS];
   logic [RMW-1:0]   rem_ff  [0:NS];
   logic [RTW-1:0]   root_ff [0:NS];
   q2e_pkg::job_type job_ff  [0:NS];

   // Square of the magnitude and the radicand.
   always_ff @(posedge clock) begin
      if (enable) begin
         n_ff[0]    <= q2e_pkg::Q56_ONE - NW'(job_in.mag * job_in.mag);
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         job_ff[0]  <= job_in;
      end
   end

   // One restoring step per stage: two radicand bits in, one root bit out.
   for (genvar k = 1; k <= NS; k++) begin : g_step
      logic [RMW-1:0] cand;
      logic [RMW-1:0] sub;
      logic           take;

      assign cand = {rem_ff[k-1][RMW-3:0], n_ff[k-1][NW-1 -: 2]};
      assign sub  = {1'b0, root_ff[k-1], 2'b01};
      assign take = (cand >= sub);

      always_ff @(posedge clock) begin
         if (enable) begin
            n_ff[k]    <= n_ff[k-1] << 2;
            rem_ff[k]  <= take ? cand - sub : cand;
            root_ff[k] <= {root_ff[k-1][RTW-2:0], take};
            job_ff[k]  <= job_ff[k-1];
         end
      end
   end

   assign job_out  = job_ff[NS];
   assign root_out = root_ff[NS];

endmodule

`default_nettype wire

>>> rtl/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined CORDIC vectoring unit for atan2(y, x): quadrant pre-rotation,
// one iteration per stage, then rounding to Q3.13 and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic #(
   parameter int                 CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF,
   parameter int                 FRAC_BITS    = q2e_pkg::FRAC_BITS_DEF,
   parameter logic signed [15:0] LIMIT        = q2e_pkg::ANG_MAX_PI
) (
   input  wire logic                              clock,
   input  wire logic                              enable,
   input  wire logic signed [q2e_pkg::V_W-1:0]    y_in,
   input  wire logic signed [q2e_pkg::V_W-1:0]    x_in,
   output logic signed [15:0]                     angle
);

   localparam int NS = q2e_pkg::steps_eff(CORDIC_STEPS);
   localparam int VW = q2e_pkg::V_W;
   localparam int ZW = FRAC_BITS + 4;
   localparam int AW = ZW + 14;
   localparam logic signed [ZW-1:0] HALF_PI_ANG =
      ZW'(q2e_pkg::q30_to_ang(q2e_pkg::HALF_PI_Q30, FRAC_BITS));

   logic signed [VW-1:0] x_ff    [0:NS];
   logic signed [VW-1:0] y_ff    [0:NS];
   logic signed [ZW-1:0] z_ff    [0:NS];
   logic                 zero_ff [0:NS];
   logic signed [15:0]   angle_ff;
   logic signed [AW-1:0] ext, conv, lim;

   // Quadrant pre-rotation; a zero vector is marked and gives angle zero.
   always_ff @(posedge clock) begin
      if (enable) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            if (y_in >= 0) begin
               x_ff[0] <= y_in;
               y_ff[0] <= -x_in;
               z_ff[0] <= HALF_PI_ANG;
            end else begin
               x_ff[0] <= -y_in;
               y_ff[0] <= x_in;
               z_ff[0] <= -HALF_PI_ANG;
            end
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= '0;
         end
      end
   end

   // Micro-rotations, driving y towards zero.
   for (genvar i = 0; i < NS; i++) begin : g_iter
      localparam logic signed [ZW-1:0] ATAN_I =
         ZW'(q2e_pkg::q30_to_ang(q2e_pkg::atan_q30(i), FRAC_BITS));
      logic signed [VW-1:0] xs, ys;

      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (enable) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + ATAN_I;
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - ATAN_I;
            end
         end
      end
   end

   // Conversion of the accumulated angle to Q3.13.
   assign ext = zero_ff[NS] ? '0 : AW'(z_ff[NS]);
   assign lim = AW'(LIMIT);

   if (FRAC_BITS > 13) begin : g_round
      localparam int SH = FRAC_BITS - 13;
      assign conv = (ext + (AW'(1) <<< (SH - 1))) >>> SH;
   end else if (FRAC_BITS == 13) begin : g_same
      assign conv = ext;
   end else begin : g_widen
      localparam int SL = 13 - FRAC_BITS;
      assign conv = ext <<< SL;
   end

   // Saturation to the angle limit.
   always_ff @(posedge clock) begin
      if (enable) begin
         if (conv > lim) begin
            angle_ff <= LIMIT;
         end else if (conv < -lim) begin
            angle_ff <= -LIMIT;
         end else begin
            angle_ff <= conv[15:0];
         end
      end
   end

   assign angle = angle_ff;

endmodule

`default_nettype wire

>>> tb/q2e_angle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// q2e_angle_checker
// Watches the quaternion and angle channels, works out the expected Euler
// angles of every accepted quaternion and compares them with the responses.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_angle_checker (
   input  wire logic clock,
   input  wire logic reset,
   q2e_req_if        req_chan,
   q2e_rsp_if        rsp_chan,
   output int        fail_count,
   output int        angles_pending
);

   localparam int STEPS = q2e_pkg::CORDIC_STEPS_DEF;
   localparam int FRAC  = q2e_pkg::FRAC_BITS_DEF;

   typedef struct {
      logic signed [q2e_pkg::ROLL_W-1:0]  roll;
      logic signed [q2e_pkg::PITCH_W-1:0] pitch;
      logic signed [q2e_pkg::YAW_W-1:0]   yaw;
      logic                               clamped;
   } euler_type;

   euler_type angle_queue[$];

   // Accumulator angle converted to Q3.13, round half up.
   function automatic longint to_q13(input longint v);
      if (FRAC >= 13) begin
         if (FRAC == 13) begin
            return v;
         end
         return (v + (64'sd1 <<< (FRAC - 14))) >>> (FRAC - 13);
      end
      return v <<< (13 - FRAC);
   endfunction

   // Vectoring CORDIC arctangent of y over x.
   function automatic longint vector_angle(input longint y_in, input longint x_in);
      longint x, y, z, t, xs, ys;
      int n;
      x = x_in;
      y = y_in;
      z = 0;
      if (x == 0 && y == 0) begin
         return 0;
      end
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = q2e_pkg::q30_to_ang(q2e_pkg::HALF_PI_Q30, FRAC);
         end else begin
            x = -y;
            y = t;
            z = -q2e_pkg::q30_to_ang(q2e_pkg::HALF_PI_Q30, FRAC);
         end
      end
      n = (STEPS > q2e_pkg::ATAN_TAB_LEN) ? q2e_pkg::ATAN_TAB_LEN : STEPS;
      for (int i = 0; i < n; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + q2e_pkg::q30_to_ang(q2e_pkg::atan_q30(i), FRAC);
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - q2e_pkg::q30_to_ang(q2e_pkg::atan_q30(i), FRAC);
         end
      end
      return z;
   endfunction

   // Floor integer square root.
   function automatic longint floor_sqrt(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) begin
         b = b >> 2;
      end
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint limit(input longint v, input longint lim);
      return (v > lim) ? lim : ((v < -lim) ? -lim : v);
   endfunction

   function automatic euler_type predict_euler(input longint w, input longint x,
                                               input longint y, input longint z);
      euler_type e;
      longint one, sp, c, p;
      longint unsigned a;
      one = 64'sd1 <<< 28;
      e.roll = q2e_pkg::ROLL_W'(limit(to_q13(vector_angle(2 * (w * x + y * z),
                           one - 2 * (x * x + y * y))), q2e_pkg::ANG_MAX_PI));
      e.yaw = q2e_pkg::YAW_W'(limit(to_q13(vector_angle(2 * (w * z + x * y),
                           one - 2 * (y * y + z * z))), q2e_pkg::ANG_MAX_PI));
      sp = 2 * (w * y - z * x);
      if (sp >= one || sp <= -one) begin
         p = (sp > 0) ? q2e_pkg::ANG_MAX_HALF : -q2e_pkg::ANG_MAX_HALF;
         e.clamped = 1'b1;
      end else begin
         a = (sp < 0) ? -sp : sp;
         c = floor_sqrt((64'd1 << 56) - a * a);
         p = limit(to_q13(vector_angle(sp, c)), q2e_pkg::ANG_MAX_HALF);
         e.clamped = 1'b0;
      end
      e.pitch = q2e_pkg::PITCH_W'(p);
      return e;
   endfunction

   assign angles_pending = angle_queue.size();

   // Expected angles are queued on input transactions and checked on output ones.
   always @(posedge clock) begin
      euler_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            angle_queue.push_back(predict_euler(req_chan.qw, req_chan.qx,
                                                req_chan.qy, req_chan.qz));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (angle_queue.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected response roll %0d pitch %0d yaw %0d",
                           rsp_chan.roll, rsp_chan.pitch, rsp_chan.yaw);
               end
               fail_count <= fail_count + 1;
            end else begin
               e = angle_queue.pop_front();
               if (e.roll !== rsp_chan.roll || e.pitch !== rsp_chan.pitch ||
                   e.yaw !== rsp_chan.yaw || e.clamped !== rsp_chan.pitch_clamped) begin
                  if (fail_count < 10) begin
                     $display("mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                              e.roll, e.pitch, e.yaw, e.clamped, rsp_chan.roll,
                              rsp_chan.pitch, rsp_chan.yaw, rsp_chan.pitch_clamped);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

`default_nettype wire

>>> tb/quaternion_to_euler_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_core_test
// Drives directed and random quaternions through the converter under varying
// idle and stall patterns; the checker compares every response.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_core_test;

   localparam int LATENCY   = 49;
   localparam int MAX_CYCLE = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   angles_pending;
   int   cycle_count = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   bit   hold_off = 1'b0;
   int   hold_cycles = 0;

   q2e_req_if req_chan ();
   q2e_rsp_if rsp_chan ();

   quaternion_to_euler_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   q2e_angle_checker u_angle_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .fail_count     (fail_count),
      .angles_pending (angles_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("quaternion_to_euler_core_test: done, errors");
         $finish;
      end
   end

   // Receiver: random stalls, or a long hold-off counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_off) begin
         rsp_chan.ready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles >= 200) begin
            hold_off <= 1'b0;
         end
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [q2e_pkg::IN_W-1:0] pick_component();
      case ($urandom_range(9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'h0000;
         3: return 16'($urandom);
         default: return 16'($signed($urandom_range(32768)) - 16384);
      endcase
   endfunction

   // Offers one quaternion and holds it until the block takes it.
   task automatic send_quat(input logic [q2e_pkg::IN_W-1:0] w,
                            input logic [q2e_pkg::IN_W-1:0] x,
                            input logic [q2e_pkg::IN_W-1:0] y,
                            input logic [q2e_pkg::IN_W-1:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.qw <= w;
      req_chan.qx <= x;
      req_chan.qy <= y;
      req_chan.qz <= z;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   initial begin
      int n;
      req_chan.valid = 1'b0;
      req_chan.qw = '0;
      req_chan.qx = '0;
      req_chan.qy = '0;
      req_chan.qz = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity, zero, extremes, axis turns, gimbal lock, negative x.
      send_quat(16'sd16384, 0, 0, 0);
      send_quat(0, 0, 0, 0);
      send_quat(-16'sd16384, 0, 0, 0);
      send_quat(0, 16'sd16384, 0, 0);
      send_quat(0, 0, 16'sd16384, 0);
      send_quat(0, 0, 0, 16'sd16384);
      send_quat(0, 0, 0, -16'sd16384);
      send_quat(16'sd11585, 0, 16'sd11585, 0);
      send_quat(16'sd11585, 0, -16'sd11585, 0);
      send_quat(16'sd11586, 0, 16'sd11586, 0);
      send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
      send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_quat(16'sd8192, 16'sd8192, 16'sd8192, -16'sd8192);
      send_quat(0, 16'sd11585, 16'sd11585, 0);

      // Random phases with differing idle and stall rates.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            default: begin
               send_idle_pct = 0; recv_stall_pct = 0;
               hold_off <= 1'b1;
            end
         endcase
         n = (ph == 0) ? 240 : 190;
         repeat (n) send_quat(pick_component(), pick_component(),
                              pick_component(), pick_component());
      end
      req_chan.valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;

      while (angles_pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("quaternion_to_euler_core_test: done, clean");
      end else begin
         $display("quaternion_to_euler_core_test: done, errors");
      end
      $finish;
   end
endmodule

`default_nettype wire
